>>> rtl/core/srq_pkg.sv
// Shared types, constants and key selection for the sorted ready queue.
// No dependencies; compiled first.
package srq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;

    // Register addresses
    localparam logic [PADDR_W-1:0] ADDR_SORT_MODE = 3'd0;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Sort mode codes
    localparam logic [1:0] MODE_NUMBER   = 2'd0;
    localparam logic [1:0] MODE_PRIORITY = 2'd1;
    localparam logic [1:0] MODE_BURST    = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0]  number;
        logic [7:0]  prio;
        logic [7:0]  burst;
        logic [31:0] handle;
    } srq_entry_t;

    // Control word broadcast to every cell
    typedef struct packed {
        logic       ins_en;
        logic       pop_en;
        logic [1:0] mode;
    } srq_ctl_t;

    // Ordering key of an entry; the unused mode code orders by number
    function automatic logic [7:0] key_of(input srq_entry_t e, input logic [1:0] mode);
        logic [7:0] k;
        unique case (mode)
            MODE_PRIORITY: k = e.prio;
            MODE_BURST:    k = e.burst;
            default:       k = e.number;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/core/srq_in_if.sv
// Input channel of the sorted ready queue: valid/ready plus one request word.
// Depends on nothing.
interface srq_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  task_number;
    logic [7:0]  task_priority;
    logic [7:0]  task_burst;
    logic [31:0] task_handle;

    modport source (output valid, op, task_number, task_priority, task_burst,
                    task_handle, input ready);
    modport sink   (input valid, op, task_number, task_priority, task_burst,
                    task_handle, output ready);
endinterface

>>> rtl/core/srq_out_if.sv
// Result channel of the sorted ready queue: valid/ready plus one result word.
// Depends on nothing.
interface srq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_number;
    logic [7:0]  out_priority;
    logic [7:0]  out_burst;
    logic [31:0] out_handle;
    logic [4:0]  occupancy;

    modport source (output valid, status, out_valid, out_number, out_priority,
                    out_burst, out_handle, occupancy, input ready);
    modport sink   (input valid, status, out_valid, out_number, out_priority,
                    out_burst, out_handle, occupancy, output ready);
endinterface

>>> rtl/core/srq_cell.sv
// One slot of the shifting sorted queue: holds an entry, decides insert/shift.
// Depends on srq_pkg.
module srq_cell
    import srq_pkg::*;
(
    input  logic       clk,
    input  srq_ctl_t   ctl,
    input  logic       head,        // first cell: strict compare
    input  logic       occ,         // slot holds a live entry
    input  logic       left_mark,   // insert point lies left of this cell
    input  srq_entry_t new_entry,
    input  srq_entry_t left_entry,
    input  srq_entry_t right_entry,
    output logic       mark,        // insert point at or left of this cell
    output srq_entry_t entry
);

    srq_entry_t entry_reg;
    srq_entry_t entry_next;
    logic [7:0] my_key;
    logic [7:0] new_key;
    logic       here;

    assign my_key  = key_of(entry_reg, ctl.mode);
    assign new_key = key_of(new_entry, ctl.mode);

    // head goes first only on strictly greater key; later slots on not smaller
    always_comb
    begin
        if (head)
        begin
            here = !occ || (my_key > new_key);
        end
        else
        begin
            here = !occ || (my_key >= new_key);
        end
    end

    assign mark  = left_mark || here;
    assign entry = entry_reg;

    // next slot content
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.pop_en)
        begin
            entry_next = right_entry;
        end
        else if (ctl.ins_en)
        begin
            if (left_mark)
            begin
                entry_next = left_entry;
            end
            else if (here)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/core/sorted_ready_queue.sv
// Sorted ready queue: a row of shifting cells kept in key order.
// Depends on srq_pkg, srq_in_if, srq_out_if and srq_cell.
// An accepted word's result is held in the output register in the next cycle.
// Throughput: one word per cycle while out_ch is ready; cells move in parallel.
// Reset: entry count and sort mode cleared, result register empty;
// slot contents are not cleared and hold no meaning beyond the count.
module sorted_ready_queue
    import srq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    srq_in_if.sink             in_ch,
    srq_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0]         mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               res_valid_reg;
    logic [1:0]         res_status_reg;
    logic               res_out_valid_reg;
    srq_entry_t         res_entry_reg;
    logic [4:0]         res_occ_reg;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    srq_ctl_t   ctl;
    logic [1:0] status_next;
    srq_entry_t new_entry;

    srq_entry_t cell_entry [QUEUE_DEPTH];
    logic       cell_mark  [QUEUE_DEPTH];

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NUMBER;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_SORT_MODE))
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SORT_MODE)
        begin
            prdata = {30'd0, mode_reg};
        end
    end

    // handshake
    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign is_full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign new_entry.number = in_ch.task_number;
    assign new_entry.prio   = in_ch.task_priority;
    assign new_entry.burst  = in_ch.task_burst;
    assign new_entry.handle = in_ch.task_handle;

    // operation decode
    always_comb
    begin
        ctl.mode    = mode_reg;
        ctl.ins_en  = 1'b0;
        ctl.pop_en  = 1'b0;
        status_next = STATUS_DONE;
        count_next  = count_reg;
        if (accept)
        begin
            unique case (in_ch.op)
                OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.ins_en = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_en = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // row of cells, head at index 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic       occ;
        logic       left_mark;
        srq_entry_t left_entry;
        srq_entry_t right_entry;

        assign occ = (COUNT_W'(g) < count_reg);

        if (g == 0)
        begin : g_head
            assign left_mark  = 1'b0;
            assign left_entry = new_entry;
        end
        else
        begin : g_body
            assign left_mark  = cell_mark[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[g];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        srq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .head        (g == 0),
            .occ         (occ),
            .left_mark   (left_mark),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .mark        (cell_mark[g]),
            .entry       (cell_entry[g])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg    <= status_next;
            res_out_valid_reg <= ctl.pop_en;
            res_entry_reg     <= ctl.pop_en ? cell_entry[0] : '0;
            res_occ_reg       <= 5'(count_next);
        end
    end

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.status       = res_status_reg;
    assign out_ch.out_valid    = res_out_valid_reg;
    assign out_ch.out_number   = res_entry_reg.number;
    assign out_ch.out_priority = res_entry_reg.prio;
    assign out_ch.out_burst    = res_entry_reg.burst;
    assign out_ch.out_handle   = res_entry_reg.handle;
    assign out_ch.occupancy    = res_occ_reg;

endmodule

>>> rtl/core/srq_checker.sv
// Port-level checks for the sorted ready queue, bound to the top level.
// Depends on srq_pkg and sorted_ready_queue.
module srq_checker
    import srq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [1:0]  status,
    input  logic        out_valid,
    input  logic [7:0]  out_number,
    input  logic [31:0] out_handle,
    input  logic [4:0]  occupancy
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(occupancy))
        else $error("result word changed while stalled");

    // a returned task always comes with done status
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == STATUS_DONE)
        else $error("popped task with error status");

    // no task returned means zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_number == 8'd0 && out_handle == 32'd0)
        else $error("nonzero payload without popped task");

    // error codes agree with the occupancy reported
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == STATUS_EMPTY) |-> occupancy == 5'd0)
        else $error("empty-pop status with nonzero occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == STATUS_FULL) |-> occupancy == 5'(QUEUE_DEPTH))
        else $error("full-drop status without full occupancy");

endmodule

bind sorted_ready_queue srq_checker u_srq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .status     (out_ch.status),
    .out_valid  (out_ch.out_valid),
    .out_number (out_ch.out_number),
    .out_handle (out_ch.out_handle),
    .occupancy  (out_ch.occupancy)
);

>>> dv/tb_sorted_ready_queue.sv
// Self-checking testbench for sorted_ready_queue: directed table, then randomized
// insert/pop traffic per sort mode, checked against an in-bench model of the queue.
// Depends on srq_pkg, srq_in_if, srq_out_if and the sorted_ready_queue RTL.
module tb_sorted_ready_queue;
    import srq_pkg::*;

    // Mode code the register accepts but does not define; orders like MODE_NUMBER
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         PHASE_WORDS  = 305;
    localparam int         NUM_PHASES   = 6;

    // One task as the queue stores it
    typedef struct packed {
        logic [7:0]  number;
        logic [7:0]  prio;
        logic [7:0]  burst;
        logic [31:0] handle;
    } task_rec_t;

    typedef struct packed {
        logic      op;
        task_rec_t rec;
    } task_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       got;
        task_rec_t  rec;
        logic [4:0] occ;
    } queue_result_t;

    typedef struct packed {
        task_req_t     req;
        logic          typed;
        queue_result_t res;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    srq_in_if  in_ch();
    srq_out_if out_ch();

    sorted_ready_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state: sorted task list, its fill level and the ordering key
    task_rec_t     ready_list [QUEUE_DEPTH];
    int            ready_count = 0;
    logic [1:0]    order_mode  = MODE_NUMBER;
    queue_result_t pending_results [$];

    int  err_count   = 0;
    int  ins_placed  = 0;
    int  ins_dropped = 0;
    int  pops_served = 0;
    int  pops_empty  = 0;
    int  stall_asks  = 0;
    int  stall_done  = 0;
    int  hold_left   = 0;
    bit  calm        = 1'b0;

    function automatic logic [7:0] order_key(input task_rec_t t);
        logic [7:0] k;
        case (order_mode)
            MODE_PRIORITY: k = t.prio;
            MODE_BURST:    k = t.burst;
            default:       k = t.number;
        endcase
        return k;
    endfunction

    // Apply one word to the model queue and return the result it produces
    function automatic queue_result_t queue_apply(input task_req_t r);
        queue_result_t res;
        logic [7:0]    k;
        int            pos;
        res = '0;
        if (r.op == OP_INSERT)
        begin
            if (ready_count >= QUEUE_DEPTH)
            begin
                res.status = STATUS_FULL;
                ins_dropped++;
            end
            else
            begin
                k = order_key(r.rec);
                if (ready_count == 0 || order_key(ready_list[0]) > k)
                    pos = 0;
                else
                begin
                    // equal to the head key lands behind the head
                    pos = 1;
                    while (pos < ready_count && order_key(ready_list[pos]) < k)
                        pos++;
                end
                for (int i = ready_count; i > pos; i--)
                    ready_list[i] = ready_list[i-1];
                ready_list[pos] = r.rec;
                ready_count++;
                res.status = STATUS_DONE;
                ins_placed++;
            end
        end
        else
        begin
            if (ready_count == 0)
            begin
                res.status = STATUS_EMPTY;
                pops_empty++;
            end
            else
            begin
                res.status = STATUS_DONE;
                res.got    = 1'b1;
                res.rec    = ready_list[0];
                for (int i = 1; i < ready_count; i++)
                    ready_list[i-1] = ready_list[i];
                ready_count--;
                pops_served++;
            end
        end
        res.occ = ready_count[4:0];
        return res;
    endfunction

    function automatic dir_row_t plain(input logic op, input logic [7:0] n, input logic [7:0] p,
                                       input logic [7:0] b, input logic [31:0] h);
        dir_row_t row;
        row       = '0;
        row.req   = '{op, '{n, p, b, h}};
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic dir_row_t known(input logic op, input logic [7:0] n, input logic [7:0] p,
                                       input logic [7:0] b, input logic [31:0] h,
                                       input logic [1:0] st, input logic got,
                                       input task_rec_t back, input logic [4:0] occ);
        dir_row_t row;
        row       = plain(op, n, p, b, h);
        row.typed = 1'b1;
        row.res   = '{st, got, back, occ};
        return row;
    endfunction

    // Mostly full range, often a narrow band so ties occur, sometimes an extreme
    function automatic logic [7:0] draw_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return 8'($urandom_range(255));
        else if (pick < 9)
            return 8'($urandom_range(7));
        else
            return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    function automatic task_req_t draw_req(input int ins_pct);
        task_req_t r;
        r.op         = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_POP;
        r.rec.number = draw_key();
        r.rec.prio   = draw_key();
        r.rec.burst  = draw_key();
        r.rec.handle = $urandom;
        return r;
    endfunction

    // Offer one word, wait for the handshake, then record what should come back
    task automatic send_word(input task_req_t r, input logic typed, input queue_result_t tres);
        queue_result_t res;
        in_ch.valid         <= 1'b1;
        in_ch.op            <= r.op;
        in_ch.task_number   <= r.rec.number;
        in_ch.task_priority <= r.rec.prio;
        in_ch.task_burst    <= r.rec.burst;
        in_ch.task_handle   <= r.rec.handle;
        do
            @(posedge clk);
        while (!in_ch.ready);
        res = queue_apply(r);
        pending_results.push_back(typed ? tres : res);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(99) < 22)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain_all();
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_SORT_MODE)
            order_mode = d[1:0];
        @(posedge clk);
    endtask

    task automatic apb_check_mode();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SORT_MODE;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[1:0] !== order_mode)
        begin
            $display("%0t: sort_mode readback expected %0h got %0h", $time, order_mode,
                     prdata[1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
            err_count++;
        end
    endfunction

    // Result side: compare every accepted word against the oldest expectation
    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, status %0h occupancy %0d", $time,
                         out_ch.status, out_ch.occupancy);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, out_ch.status);
                check_field("out_valid", want.got, out_ch.out_valid);
                check_field("out_number", want.rec.number, out_ch.out_number);
                check_field("out_priority", want.rec.prio, out_ch.out_priority);
                check_field("out_burst", want.rec.burst, out_ch.out_burst);
                check_field("out_handle", want.rec.handle, out_ch.out_handle);
                check_field("occupancy", want.occ, out_ch.occupancy);
            end
        end
    end

    // Result side ready: random idling, a calm stretch, and long hold-offs on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_done != stall_asks)
            begin
                stall_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= 22);
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t     rows [$];
        task_req_t    r;
        logic [1:0]   phase_mode [NUM_PHASES];
        logic [31:0]  wdata;
        int           ins_pct;

        phase_mode = '{MODE_PRIORITY, MODE_BURST, MODE_SPARE, MODE_NUMBER, MODE_BURST,
                       MODE_PRIORITY};

        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= OP_INSERT;
        in_ch.task_number   <= '0;
        in_ch.task_priority <= '0;
        in_ch.task_burst    <= '0;
        in_ch.task_handle   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, sort by task number (reset mode)
        rows.push_back(known(OP_POP, 8'h00, 8'h00, 8'h00, 32'h0,
                             STATUS_EMPTY, 1'b0, '0, 5'd0));
        rows.push_back(known(OP_INSERT, 8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF,
                             STATUS_DONE, 1'b0, '0, 5'd1));
        rows.push_back(known(OP_INSERT, 8'h00, 8'hFF, 8'h00, 32'h0,
                             STATUS_DONE, 1'b0, '0, 5'd2));
        rows.push_back(known(OP_POP, 8'h00, 8'h00, 8'h00, 32'h0,
                             STATUS_DONE, 1'b1, '{8'h00, 8'hFF, 8'h00, 32'h0}, 5'd1));
        // same key as the head: must queue behind it
        rows.push_back(known(OP_INSERT, 8'hFF, 8'h5A, 8'hA5, 32'h0000_0001,
                             STATUS_DONE, 1'b0, '0, 5'd2));
        rows.push_back(known(OP_POP, 8'h00, 8'h00, 8'h00, 32'h0,
                             STATUS_DONE, 1'b1, '{8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF}, 5'd1));
        // fill to capacity: middle inserts, ties, new head, tail
        rows.push_back(plain(OP_INSERT, 8'h80, 8'h11, 8'h22, 32'h1000_0001));
        rows.push_back(plain(OP_INSERT, 8'h10, 8'h33, 8'h44, 32'h1000_0002));
        rows.push_back(plain(OP_INSERT, 8'h80, 8'h55, 8'h66, 32'h1000_0003));
        rows.push_back(plain(OP_INSERT, 8'h40, 8'h77, 8'h88, 32'h1000_0004));
        rows.push_back(plain(OP_INSERT, 8'hFF, 8'h99, 8'hAA, 32'h1000_0005));
        rows.push_back(plain(OP_INSERT, 8'h00, 8'hBB, 8'hCC, 32'h1000_0006));
        rows.push_back(plain(OP_INSERT, 8'h80, 8'hDD, 8'hEE, 32'h1000_0007));
        rows.push_back(plain(OP_INSERT, 8'h20, 8'h01, 8'h02, 32'h8000_0000));
        rows.push_back(plain(OP_INSERT, 8'hC0, 8'h03, 8'h04, 32'h7FFF_FFFF));
        rows.push_back(plain(OP_INSERT, 8'h10, 8'h05, 8'h06, 32'h5555_5555));
        rows.push_back(plain(OP_INSERT, 8'h7F, 8'h07, 8'h08, 32'hAAAA_AAAA));
        rows.push_back(plain(OP_INSERT, 8'h01, 8'h09, 8'h0A, 32'h0F0F_0F0F));
        rows.push_back(plain(OP_INSERT, 8'hFE, 8'h0B, 8'h0C, 32'hF0F0_F0F0));
        rows.push_back(plain(OP_INSERT, 8'h80, 8'h0D, 8'h0E, 32'h1234_5678));
        rows.push_back(plain(OP_INSERT, 8'h55, 8'h0F, 8'h10, 32'h8765_4321));
        rows.push_back(known(OP_INSERT, 8'h33, 8'h33, 8'h33, 32'hDEAD_BEEF,
                             STATUS_FULL, 1'b0, '0, 5'd16));
        rows.push_back(plain(OP_POP, 8'h00, 8'h00, 8'h00, 32'h0));

        apb_check_mode();
        foreach (rows[k])
        begin
            send_word(rows[k].req, rows[k].typed, rows[k].res);
            maybe_gap();
        end
        drain_all();

        // Random phases, one sort mode each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wdata = {30'b0, phase_mode[ph]};
            // upper bits of the write word carry no meaning
            if (ph == 3)
                wdata = ($urandom & 32'hFFFF_FFFC) | wdata;
            apb_write(ADDR_SORT_MODE, wdata);
            apb_check_mode();
            calm = (ph == 1);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (ph == 1 && i == 200)
                    calm = 1'b0;
                if (i == 100)
                    stall_asks++;
                if (i >= 100 && i < 140)
                    ins_pct = 90;
                else
                    ins_pct = ((i / 40) % 2 == 0) ? 72 : 30;
                if (i == 160)
                    drain_all();
                r = draw_req(ins_pct);
                send_word(r, 1'b0, '0);
                maybe_gap();
            end
            drain_all();
        end

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (6) @(posedge clk);
        $display("Covered: %0d inserts placed, %0d dropped on full, %0d pops served,",
                 ins_placed, ins_dropped, pops_served);
        $display("%0d pops on empty, across all four sort mode codes with stalls on both sides",
                 pops_empty);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(8 * 400000);
        $display("%0t: run timed out with %0d results outstanding", $time,
                 pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sorted_ready_queue.f
rtl/core/srq_pkg.sv
rtl/core/srq_in_if.sv
rtl/core/srq_out_if.sv
rtl/core/srq_cell.sv
rtl/core/sorted_ready_queue.sv
rtl/core/srq_checker.sv
dv/tb_sorted_ready_queue.sv
